>>> hw/rtl/wmie_pkg.sv
`timescale 1ns / 1ps

package wmie_pkg;

  // ssid storage geometry: two banks of SSID_MAX bytes
  localparam int SSID_MAX   = 32;
  localparam int SSID_IDX_W = $clog2(SSID_MAX);
  localparam int SSID_LEN_W = SSID_IDX_W + 1;
  localparam int SSID_BANKS = 2;
  localparam int RAM_DEPTH  = SSID_BANKS * SSID_MAX;
  localparam int RAM_AW     = $clog2(RAM_DEPTH);

  // frame layout
  localparam logic [7:0] SUBTYPE_MASK    = 8'hF0;
  localparam logic [7:0] SUB_BEACON      = 8'h80;
  localparam logic [7:0] SUB_PROBE_REQ   = 8'h40;
  localparam logic [7:0] SUB_PROBE_RESP  = 8'h50;
  localparam logic [7:0] MCAST_BIT       = 8'h01;
  localparam int         FCS_BYTES       = 4;
  localparam int         ADDR2_FIRST     = 10;
  localparam int         ADDR2_LAST      = 15;
  localparam int         START_PROBE_REQ = 24;
  localparam int         START_DEFAULT   = 36;

  // element ids
  localparam logic [7:0] EID_SSID = 8'h00;
  localparam logic [7:0] EID_DS   = 8'h03;
  localparam logic [7:0] EID_NONE = 8'hFF;

  // one kept frame, waiting to be emitted
  typedef struct packed {
    logic [47:0]           addr;
    logic [7:0]            channel;
    logic [7:0]            rssi;
    logic [SSID_LEN_W-1:0] len;
    logic                  bank;
  } desc_t;

  // back end hands an ssid bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  // ssid byte write into the bank memory
  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ssid_wr_t;

endpackage

>>> hw/rtl/wifi_mgmt_frame_ie_parser.sv
`timescale 1ns / 1ps

// Beacon / probe SSID extractor. Frame bytes enter one per clock; the parser
// keeps the frame control byte and address 2, walks the tagged elements and
// writes the winning SSID into one of two 32-byte banks of a small RAM. A
// kept frame leaves a descriptor in a two-entry queue, and the emitter then
// delivers one beat per SSID byte, one per clock while out_ready is high,
// with out_valid first rising once the descriptor has passed the read
// stage and the output register. Input runs at one byte per cycle; it
// stalls only at the start of a frame when both SSID banks still hold
// frames waiting to be emitted, so the sustained rate is set by how fast
// the kept SSIDs are emitted.
module wifi_mgmt_frame_ie_parser #(
  parameter int LENGTH_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_frame_byte,
  input  logic [LENGTH_BITS-1:0]             in_frame_length,
  input  logic                               in_is_management,
  input  logic signed [7:0]                  in_rssi,
  input  logic [7:0]                         in_current_channel,
  input  logic                               in_end_of_frame,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [47:0]                        out_transmitter_address,
  output logic [7:0]                         out_channel,
  output logic signed [7:0]                  out_frame_rssi,
  output logic [wmie_pkg::SSID_LEN_W-1:0]    out_ssid_length,
  output logic [7:0]                         out_ssid_byte,
  output logic [wmie_pkg::SSID_IDX_W-1:0]    out_byte_index,
  output logic                               out_last_of_run
);

  import wmie_pkg::*;

  ssid_wr_t          ssid_wr;
  logic              push_valid;
  desc_t             push_desc;
  bank_rel_t         bank_rel;
  logic              q_valid;
  desc_t             q_desc;
  logic              q_pop;
  logic              rd_en;
  logic [RAM_AW-1:0] rd_addr;
  logic [7:0]        rd_data;

  // parser front end
  wmie_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_frame_byte     (in_frame_byte),
    .in_frame_length   (in_frame_length),
    .in_is_management  (in_is_management),
    .in_rssi           (in_rssi),
    .in_current_channel(in_current_channel),
    .in_end_of_frame   (in_end_of_frame),
    .ssid_wr           (ssid_wr),
    .push_valid        (push_valid),
    .push_desc         (push_desc),
    .bank_rel          (bank_rel)
  );

  // ssid banks
  wmie_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_ssid_ram (
    .clk    (clk),
    .wr_en  (ssid_wr.en),
    .wr_addr(ssid_wr.addr),
    .wr_data(ssid_wr.data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // queue of kept frames
  wmie_desc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_desc (push_desc),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_desc  (q_desc)
  );

  // result emitter
  wmie_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .desc_valid             (q_valid),
    .desc                   (q_desc),
    .desc_pop               (q_pop),
    .rd_en                  (rd_en),
    .rd_addr                (rd_addr),
    .rd_data                (rd_data),
    .bank_rel               (bank_rel),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_transmitter_address(out_transmitter_address),
    .out_channel            (out_channel),
    .out_frame_rssi         (out_frame_rssi),
    .out_ssid_length        (out_ssid_length),
    .out_ssid_byte          (out_ssid_byte),
    .out_byte_index         (out_byte_index),
    .out_last_of_run        (out_last_of_run)
  );

endmodule

>>> hw/rtl/wmie_ram.sv
`timescale 1ns / 1ps

module wmie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/wmie_front.sv
`timescale 1ns / 1ps

module wmie_front #(
  parameter int LENGTH_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_frame_byte,
  input  logic [LENGTH_BITS-1:0] in_frame_length,
  input  logic                   in_is_management,
  input  logic signed [7:0]      in_rssi,
  input  logic [7:0]             in_current_channel,
  input  logic                   in_end_of_frame,
  output wmie_pkg::ssid_wr_t     ssid_wr,
  output logic                   push_valid,
  output wmie_pkg::desc_t        push_desc,
  input  wmie_pkg::bank_rel_t    bank_rel
);

  import wmie_pkg::*;

  localparam int LB = LENGTH_BITS;

  typedef enum logic [1:0] {PH_TAG, PH_LEN, PH_BODY, PH_SSID} phase_t;

  logic [LB-1:0]         pos_r, pos_nxt;
  logic [7:0]            fc_r, fc_nxt;
  logic [47:0]           addr_r, addr_nxt;
  phase_t                phase_r, phase_nxt;
  logic [7:0]            eid_r, eid_nxt;
  logic [7:0]            remain_r, remain_nxt;
  logic                  stopped_r, stopped_nxt;
  logic [SSID_LEN_W-1:0] scount_r, scount_nxt;
  logic [7:0]            chan_r, chan_nxt;
  logic                  bank_r, bank_nxt;
  logic [1:0]            busy_r, busy_nxt;

  logic                  acc;
  logic [LB-1:0]         eff_len;
  logic [LB-1:0]         start;
  logic [7:0]            sub;
  logic                  do_parse;
  logic [7:0]            eid_eff;
  logic [7:0]            ssid_off;
  logic                  keep;
  logic                  sub_ok;

  assign in_ready = !busy_r[bank_r];
  assign acc      = in_valid && in_ready;

  // effective length without the fcs
  assign eff_len = (in_frame_length > LB'(FCS_BYTES)) ?
                   (in_frame_length - LB'(FCS_BYTES)) : '0;

  // header capture and element walk
  always_comb begin
    fc_nxt     = (pos_r == '0) ? in_frame_byte : fc_r;
    addr_nxt   = addr_r;
    if (pos_r >= LB'(ADDR2_FIRST) && pos_r <= LB'(ADDR2_LAST)) begin
      addr_nxt = {addr_r[39:0], in_frame_byte};
    end
    sub        = fc_nxt & SUBTYPE_MASK;
    start      = (sub == SUB_PROBE_REQ) ? LB'(START_PROBE_REQ) : LB'(START_DEFAULT);
    do_parse   = !stopped_r && (pos_r < eff_len) && (pos_r >= start);
    phase_nxt  = phase_r;
    eid_nxt    = eid_r;
    remain_nxt = remain_r;
    stopped_nxt = stopped_r;
    scount_nxt = scount_r;
    chan_nxt   = chan_r;
    eid_eff    = (eid_r == EID_DS && in_frame_byte != 8'd1) ? EID_NONE : eid_r;
    ssid_off   = {2'b00, scount_r} - remain_r;
    ssid_wr.en   = 1'b0;
    ssid_wr.addr = {bank_r, ssid_off[SSID_IDX_W-1:0]};
    ssid_wr.data = in_frame_byte;
    if (do_parse) begin
      case (phase_r)
        PH_TAG: begin
          if (({1'b0, pos_r} + (LB+1)'(2)) >= {1'b0, eff_len}) begin
            stopped_nxt = 1'b1;
          end else begin
            eid_nxt   = in_frame_byte;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (({2'b00, pos_r} + (LB+2)'(1) + (LB+2)'(in_frame_byte)) >
              {2'b00, eff_len}) begin
            stopped_nxt = 1'b1;
          end else begin
            eid_nxt = eid_eff;
            if (in_frame_byte == 8'd0) begin
              phase_nxt = PH_TAG;
            end else if (eid_eff == EID_SSID && in_frame_byte <= 8'(SSID_MAX)) begin
              scount_nxt = SSID_LEN_W'(in_frame_byte);
              remain_nxt = in_frame_byte;
              phase_nxt  = PH_SSID;
            end else begin
              remain_nxt = in_frame_byte;
              phase_nxt  = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (eid_r == EID_DS) begin
            chan_nxt = in_frame_byte;
          end
          remain_nxt = remain_r - 8'd1;
          if (remain_r == 8'd1) begin
            phase_nxt = PH_TAG;
          end
        end
        PH_SSID: begin
          ssid_wr.en = acc;
          remain_nxt = remain_r - 8'd1;
          if (remain_r == 8'd1) begin
            phase_nxt = PH_TAG;
          end
        end
        default: begin
          phase_nxt = PH_TAG;
        end
      endcase
    end
    pos_nxt = (pos_r != '1) ? (pos_r + LB'(1)) : pos_r;
  end

  // frame decision on the last byte
  assign sub_ok = (sub == SUB_BEACON) || (sub == SUB_PROBE_REQ) || (sub == SUB_PROBE_RESP);
  assign keep = in_is_management && (in_frame_length > LB'(FCS_BYTES)) && sub_ok &&
                ((addr_nxt[47:40] & MCAST_BIT) == 8'h00) &&
                (({1'b0, pos_r} + (LB+1)'(1)) >= {1'b0, eff_len}) &&
                (scount_nxt != '0);

  assign push_valid        = acc && in_end_of_frame && keep;
  assign push_desc.addr    = addr_nxt;
  assign push_desc.channel = (chan_nxt != 8'd0) ? chan_nxt : in_current_channel;
  assign push_desc.rssi    = in_rssi;
  assign push_desc.len     = scount_nxt;
  assign push_desc.bank    = bank_r;

  // bank ownership
  always_comb begin
    busy_nxt = busy_r;
    bank_nxt = bank_r;
    if (bank_rel.valid) begin
      busy_nxt[bank_rel.bank] = 1'b0;
    end
    if (push_valid) begin
      busy_nxt[bank_r] = 1'b1;
      bank_nxt         = !bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      fc_r      <= '0;
      addr_r    <= '0;
      phase_r   <= PH_TAG;
      eid_r     <= '0;
      remain_r  <= '0;
      stopped_r <= 1'b0;
      scount_r  <= '0;
      chan_r    <= '0;
      bank_r    <= 1'b0;
      busy_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      bank_r <= bank_nxt;
      if (acc) begin
        if (in_end_of_frame) begin
          pos_r     <= '0;
          fc_r      <= '0;
          addr_r    <= '0;
          phase_r   <= PH_TAG;
          eid_r     <= '0;
          remain_r  <= '0;
          stopped_r <= 1'b0;
          scount_r  <= '0;
          chan_r    <= '0;
        end else begin
          pos_r     <= pos_nxt;
          fc_r      <= fc_nxt;
          addr_r    <= addr_nxt;
          phase_r   <= phase_nxt;
          eid_r     <= eid_nxt;
          remain_r  <= remain_nxt;
          stopped_r <= stopped_nxt;
          scount_r  <= scount_nxt;
          chan_r    <= chan_nxt;
        end
      end
    end
  end

  // the bank being filled is never one still awaiting emission
  a_fill_bank_free: assert property (@(posedge clk) disable iff (!rst_n)
    ssid_wr.en |-> !busy_r[bank_r])
    else $error("ssid write into a busy bank");

endmodule

>>> hw/rtl/wmie_desc_fifo.sv
`timescale 1ns / 1ps

module wmie_desc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  wmie_pkg::desc_t push_desc,
  input  logic            pop,
  output logic            pop_valid,
  output wmie_pkg::desc_t pop_desc
);

  import wmie_pkg::*;

  desc_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign pop_valid = (count_r != 2'd0);
  assign pop_desc  = mem_r[rd_ptr_r];

  // two-entry queue between parser and emitter
  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push_valid} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (count_r != 2'd2) || pop)
    else $error("descriptor queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("descriptor queue underflow");

endmodule

>>> hw/rtl/wmie_back.sv
`timescale 1ns / 1ps

module wmie_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                desc_valid,
  input  wmie_pkg::desc_t                     desc,
  output logic                                desc_pop,
  output logic                                rd_en,
  output logic [wmie_pkg::RAM_AW-1:0]         rd_addr,
  input  logic [7:0]                          rd_data,
  output wmie_pkg::bank_rel_t                 bank_rel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [47:0]                         out_transmitter_address,
  output logic [7:0]                          out_channel,
  output logic signed [7:0]                   out_frame_rssi,
  output logic [wmie_pkg::SSID_LEN_W-1:0]     out_ssid_length,
  output logic [7:0]                          out_ssid_byte,
  output logic [wmie_pkg::SSID_IDX_W-1:0]     out_byte_index,
  output logic                                out_last_of_run
);

  import wmie_pkg::*;

  logic [SSID_IDX_W-1:0] k_r;
  logic                  issue;
  logic                  is_last;
  logic                  out_free;
  logic                  s1_free;

  logic                  s1_valid_r;
  desc_t                 s1_desc_r;
  logic [SSID_IDX_W-1:0] s1_idx_r;
  logic                  s1_last_r;

  logic                  out_valid_r;
  logic [47:0]           out_addr_r;
  logic [7:0]            out_chan_r;
  logic [7:0]            out_rssi_r;
  logic [SSID_LEN_W-1:0] out_len_r;
  logic [7:0]            out_byte_r;
  logic [SSID_IDX_W-1:0] out_idx_r;
  logic                  out_last_r;

  // flow control through read stage and output register
  assign out_free = !out_valid_r || out_ready;
  assign s1_free  = !s1_valid_r || out_free;
  assign issue    = desc_valid && s1_free;
  assign is_last  = (({1'b0, k_r} + SSID_LEN_W'(1)) == desc.len);

  assign rd_en          = issue;
  assign rd_addr        = {desc.bank, k_r};
  assign desc_pop       = issue && is_last;
  assign bank_rel.valid = issue && is_last;
  assign bank_rel.bank  = desc.bank;

  // byte counter walks the ssid of the head descriptor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (issue) begin
      k_r <= is_last ? '0 : (k_r + SSID_IDX_W'(1));
    end
  end

  // read stage: ram data lands next to its metadata
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_desc_r <= desc;
      s1_idx_r  <= k_r;
      s1_last_r <= is_last;
    end
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= issue;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s1_valid_r && out_free) begin
      out_addr_r <= s1_desc_r.addr;
      out_chan_r <= s1_desc_r.channel;
      out_rssi_r <= s1_desc_r.rssi;
      out_len_r  <= s1_desc_r.len;
      out_byte_r <= rd_data;
      out_idx_r  <= s1_idx_r;
      out_last_r <= s1_last_r;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_transmitter_address = out_addr_r;
  assign out_channel             = out_chan_r;
  assign out_frame_rssi          = $signed(out_rssi_r);
  assign out_ssid_length         = out_len_r;
  assign out_ssid_byte           = out_byte_r;
  assign out_byte_index          = out_idx_r;
  assign out_last_of_run         = out_last_r;

  a_last_matches_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> ({1'b0, out_idx_r} + SSID_LEN_W'(1)) == out_len_r)
    else $error("last beat of run does not match ssid length");

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> {1'b0, out_idx_r} < out_len_r)
    else $error("byte index beyond ssid length");

endmodule

>>> dv/tb_wifi_mgmt_frame_ie_parser.sv
`timescale 1ns / 1ps

module tb_wifi_mgmt_frame_ie_parser;
  import wmie_pkg::*;

  localparam int LEN_W        = 12;
  localparam int POS_MAX      = (1 << LEN_W) - 1;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 32;

  typedef enum logic [1:0] {WALK_TAG, WALK_LEN, WALK_BODY, WALK_SSID} walk_t;

  // one received byte with its side fields
  typedef struct packed {
    logic [7:0]       data;
    logic [LEN_W-1:0] flen;
    logic             mgmt;
    logic [7:0]       rssi;
    logic [7:0]       cur_ch;
    logic             eof;
  } rx_beat_t;

  // one emitted ssid byte
  typedef struct packed {
    logic [47:0]           addr;
    logic [7:0]            chan;
    logic [7:0]            rssi;
    logic [SSID_LEN_W-1:0] len;
    logic [7:0]            sbyte;
    logic [SSID_IDX_W-1:0] idx;
    logic                  last;
  } ssid_beat_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [7:0]                    in_frame_byte;
  logic [LEN_W-1:0]              in_frame_length;
  logic                          in_is_management;
  logic signed [7:0]             in_rssi;
  logic [7:0]                    in_current_channel;
  logic                          in_end_of_frame;
  logic                          out_valid;
  logic                          out_ready;
  logic [47:0]                   out_transmitter_address;
  logic [7:0]                    out_channel;
  logic signed [7:0]             out_frame_rssi;
  logic [SSID_LEN_W-1:0]         out_ssid_length;
  logic [7:0]                    out_ssid_byte;
  logic [SSID_IDX_W-1:0]         out_byte_index;
  logic                          out_last_of_run;

  // parser state as tracked by the testbench
  int                    pos_q;
  logic [7:0]            fc_q;
  logic [47:0]           ta_q;
  walk_t                 walk_q;
  logic [7:0]            eid_q;
  logic [7:0]            erem_q;
  bit                    stopped_q;
  logic [7:0]            ssid_mem [SSID_MAX];
  logic [SSID_LEN_W-1:0] ssid_cnt_q;
  logic [7:0]            ds_chan_q;

  ssid_beat_t expected_ssid_beats[$];
  ssid_beat_t want_beat;
  logic [7:0] frame_q[$];
  bit         gaps_on = 1'b1;
  bit         mismatch_seen = 1'b0;
  int         beats_sent = 0;
  int         cycle_count = 0;

  wifi_mgmt_frame_ie_parser #(.LENGTH_BITS(LEN_W)) dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_frame_byte           (in_frame_byte),
    .in_frame_length         (in_frame_length),
    .in_is_management        (in_is_management),
    .in_rssi                 (in_rssi),
    .in_current_channel      (in_current_channel),
    .in_end_of_frame         (in_end_of_frame),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_transmitter_address (out_transmitter_address),
    .out_channel             (out_channel),
    .out_frame_rssi          (out_frame_rssi),
    .out_ssid_length         (out_ssid_length),
    .out_ssid_byte           (out_ssid_byte),
    .out_byte_index          (out_byte_index),
    .out_last_of_run         (out_last_of_run)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // per-frame state cleared at reset and after every end of frame
  function automatic void clear_frame_state();
    pos_q      = 0;
    fc_q       = 8'h00;
    ta_q       = 48'h0;
    walk_q     = WALK_TAG;
    eid_q      = 8'h00;
    erem_q     = 8'h00;
    stopped_q  = 1'b0;
    ssid_cnt_q = '0;
    ds_chan_q  = 8'h00;
  endfunction

  // advance the tracked parser by one accepted byte, queue any ssid beats
  function automatic void parse_rx_byte(rx_beat_t bt);
    int         p;
    int         b;
    int         len;
    int         walk_start;
    int         k;
    logic [7:0] sub;
    logic [7:0] ch;
    bit         keep;
    ssid_beat_t r;
    p   = pos_q;
    b   = bt.data;
    len = (bt.flen > FCS_BYTES) ? int'(bt.flen) - FCS_BYTES : 0;
    if (p == 0) fc_q = bt.data;
    if (p >= ADDR2_FIRST && p <= ADDR2_LAST) ta_q = {ta_q[39:0], bt.data};
    sub = fc_q & SUBTYPE_MASK;
    walk_start = (sub == SUB_PROBE_REQ) ? START_PROBE_REQ : START_DEFAULT;

    // tagged element walk
    if (!stopped_q && p < len && p >= walk_start) begin
      case (walk_q)
        WALK_TAG: begin
          if (p + 2 >= len) begin
            stopped_q = 1'b1;
          end else begin
            eid_q  = bt.data;
            walk_q = WALK_LEN;
          end
        end
        WALK_LEN: begin
          if (p + 1 + b > len) begin
            stopped_q = 1'b1;
          end else begin
            if (eid_q == EID_DS && b != 1) eid_q = EID_NONE;
            if (b == 0) begin
              walk_q = WALK_TAG;
            end else if (eid_q == EID_SSID && b <= SSID_MAX) begin
              ssid_cnt_q = SSID_LEN_W'(b);
              erem_q     = 8'(b);
              walk_q     = WALK_SSID;
            end else begin
              erem_q = 8'(b);
              walk_q = WALK_BODY;
            end
          end
        end
        WALK_BODY: begin
          if (eid_q == EID_DS) ds_chan_q = bt.data;
          erem_q = erem_q - 8'd1;
          if (erem_q == 8'd0) walk_q = WALK_TAG;
        end
        default: begin
          ssid_mem[(int'(ssid_cnt_q) - int'(erem_q)) % SSID_MAX] = bt.data;
          erem_q = erem_q - 8'd1;
          if (erem_q == 8'd0) walk_q = WALK_TAG;
        end
      endcase
    end

    if (p < POS_MAX) pos_q = p + 1;

    // frame verdict on the last byte
    if (bt.eof) begin
      keep = bt.mgmt && bt.flen > FCS_BYTES &&
             (sub == SUB_BEACON || sub == SUB_PROBE_REQ || sub == SUB_PROBE_RESP) &&
             (ta_q[47:40] & MCAST_BIT) == 8'h00 && p + 1 >= len && ssid_cnt_q != 0;
      if (keep) begin
        ch = (ds_chan_q != 8'h00) ? ds_chan_q : bt.cur_ch;
        for (k = 0; k < ssid_cnt_q; k++) begin
          r.addr  = ta_q;
          r.chan  = ch;
          r.rssi  = bt.rssi;
          r.len   = ssid_cnt_q;
          r.sbyte = ssid_mem[k];
          r.idx   = k[SSID_IDX_W-1:0];
          r.last  = (k + 1 == ssid_cnt_q);
          expected_ssid_beats.insert(expected_ssid_beats.size(), r);
        end
      end
      clear_frame_state();
    end
  endfunction

  function automatic void check_field(string what, logic [47:0] want, logic [47:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatch_seen = 1'b1;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_ssid_beats.size() == 0) begin
        $display("%0t: unexpected ssid beat, expected none, actual byte %0h index %0d",
                 $time, out_ssid_byte, out_byte_index);
        mismatch_seen = 1'b1;
      end else begin
        want_beat = expected_ssid_beats.pop_front();
        check_field("transmitter_address", want_beat.addr, out_transmitter_address);
        check_field("channel", 48'(want_beat.chan), 48'(out_channel));
        check_field("frame_rssi", 48'(want_beat.rssi), 48'(out_frame_rssi[7:0]));
        check_field("ssid_length", 48'(want_beat.len), 48'(out_ssid_length));
        check_field("ssid_byte", 48'(want_beat.sbyte), 48'(out_ssid_byte));
        check_field("byte_index", 48'(want_beat.idx), 48'(out_byte_index));
        check_field("last_of_run", 48'(want_beat.last), 48'(out_last_of_run));
      end
    end
  end

  // result-side backpressure
  initial begin
    out_ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (gaps_on && $urandom_range(0, 9) < 2) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // send one beat and wait for it to be taken
  task automatic drive_beat(rx_beat_t bt);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_frame_byte      <= bt.data;
    in_frame_length    <= bt.flen;
    in_is_management   <= bt.mgmt;
    in_rssi            <= bt.rssi;
    in_current_channel <= bt.cur_ch;
    in_end_of_frame    <= bt.eof;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    parse_rx_byte(bt);
  endtask

  // append one byte to the frame under construction
  function automatic void add_frame_byte(logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  // frame assembly: fixed header up to the element start
  function automatic void begin_frame(logic [7:0] fc, logic [47:0] ta);
    int i;
    int hdr;
    frame_q.delete();
    hdr = ((fc & SUBTYPE_MASK) == SUB_PROBE_REQ) ? START_PROBE_REQ : START_DEFAULT;
    for (i = 0; i < hdr; i++) add_frame_byte(8'($urandom));
    frame_q[0] = fc;
    for (i = ADDR2_FIRST; i <= ADDR2_LAST; i++) frame_q[i] = ta[8*(ADDR2_LAST-i) +: 8];
  endfunction

  // one tagged element; negative fill means random body
  function automatic void put_element(logic [7:0] id, int n, int fill);
    add_frame_byte(id);
    add_frame_byte(8'(n));
    repeat (n) add_frame_byte((fill < 0) ? 8'($urandom) : 8'(fill));
  endfunction

  function automatic logic [47:0] unicast_addr();
    logic [47:0] a;
    a = {16'($urandom), 32'($urandom)};
    a[40] = 1'b0;
    return a;
  endfunction

  // deliver a frame; bytes past the built frame are random, side fields
  // vary on bytes where they take no part
  task automatic send_frame(int flen, int beats, bit mgmt);
    rx_beat_t    bt;
    int          i;
    logic [31:0] rnd;
    for (i = 0; i < beats; i++) begin
      rnd       = $urandom;
      bt.data   = (i < frame_q.size()) ? frame_q[i] : 8'($urandom);
      bt.eof    = (i == beats - 1);
      bt.flen   = flen[LEN_W-1:0];
      if (i < START_PROBE_REQ && !bt.eof && rnd[31:30] == 2'b00) bt.flen = rnd[LEN_W-1:0];
      bt.mgmt   = bt.eof ? mgmt : rnd[20];
      bt.rssi   = rnd[29:22];
      bt.cur_ch = 8'($urandom);
      drive_beat(bt);
    end
  endtask

  // whole frame plus fcs, sometimes with the fcs bytes left off
  task automatic send_whole(bit mgmt);
    int flen;
    flen = frame_q.size() + FCS_BYTES;
    send_frame(flen, $urandom_range(0, 1) ? flen : flen - FCS_BYTES, mgmt);
  endtask

  task automatic send_random_frame();
    int         kind;
    int         n_el;
    int         flen;
    int         beats;
    logic [7:0] sub;
    logic [47:0] ta;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: sub = SUB_PROBE_REQ;
      4, 5:       sub = SUB_BEACON;
      6, 7:       sub = SUB_PROBE_RESP;
      default:    sub = 8'($urandom);
    endcase
    ta = unicast_addr();
    if ($urandom_range(0, 9) == 0) ta[40] = 1'b1;
    begin_frame({sub[7:4], 4'($urandom)}, ta);

    // noise frames, otherwise well-formed elements
    if (kind < 8) begin
      frame_q.delete();
      repeat ($urandom_range(1, 60)) add_frame_byte(8'($urandom));
    end else begin
      n_el = $urandom_range(1, 4);
      repeat (n_el) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: put_element(EID_SSID, $urandom_range(0, 34), -1);
          5, 6: put_element(EID_DS, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 1, -1);
          default: put_element(8'($urandom), $urandom_range(0, 12), -1);
        endcase
      end
    end
    flen  = frame_q.size() + FCS_BYTES;
    beats = $urandom_range(0, 1) ? flen : flen - FCS_BYTES;

    // shortened length so the last elements overrun, or an early end of frame
    if (kind >= 8 && kind < 16) begin
      flen  = flen - $urandom_range(1, 10);
      beats = flen;
    end else if (kind >= 16 && kind < 22) begin
      beats = $urandom_range(1, flen - FCS_BYTES - 1);
    end
    send_frame(flen, beats, $urandom_range(0, 19) != 0);
  endtask

  // frames that produce ssid runs
  task automatic test_kept_frames();
    // full-length ssid, address with every bit but multicast set
    begin_frame(SUB_PROBE_REQ, 48'hFEFF_FFFF_FFFF);
    put_element(EID_SSID, SSID_MAX, -1);
    put_element(EID_DS, 1, 6);
    send_frame(frame_q.size() + FCS_BYTES, frame_q.size(), 1'b1);

    // empty ssid and bad ds length ignored, last ds wins and a zero channel
    // falls back to the tuned one, later all-zero ssid replaces a longer one
    begin_frame(8'h4A, unicast_addr());
    put_element(EID_SSID, 0, -1);
    put_element(EID_DS, 2, -1);
    put_element(EID_DS, 1, 11);
    put_element(EID_DS, 1, 0);
    put_element(EID_SSID, 6, -1);
    put_element(EID_SSID, 3, 0);
    send_whole(1'b1);
  endtask

  // frames that must produce nothing
  task automatic test_dropped_frames();
    begin_frame(SUB_PROBE_REQ, unicast_addr());
    put_element(EID_SSID, 1, -1);
    send_frame(frame_q.size() + FCS_BYTES, frame_q.size(), 1'b0);

    send_frame(FCS_BYTES, 6, 1'b1);
    send_frame(0, 4, 1'b1);

    begin_frame(SUB_PROBE_REQ, 48'h0100_0000_0000);
    put_element(EID_SSID, 1, -1);
    send_frame(frame_q.size() + FCS_BYTES, frame_q.size(), 1'b1);
  endtask

  // element walk edges
  task automatic test_walk_limits();
    // overrunning element stops the walk, earlier ssid kept
    begin_frame(SUB_PROBE_REQ, unicast_addr());
    put_element(EID_SSID, 1, -1);
    add_frame_byte(8'hDD);
    add_frame_byte(8'd200);
    repeat (3) add_frame_byte(8'($urandom));
    send_frame(frame_q.size() + FCS_BYTES, frame_q.size(), 1'b1);

    // ssid-like bytes in the fcs are ignored
    begin_frame(SUB_PROBE_REQ, unicast_addr());
    put_element(EID_SSID, 1, -1);
    add_frame_byte(EID_SSID);
    add_frame_byte(8'd2);
    add_frame_byte(8'h41);
    add_frame_byte(8'h42);
    send_frame(frame_q.size(), frame_q.size(), 1'b1);
  endtask

  // end of frame before the last counted byte
  task automatic test_truncated_frames();
    begin_frame(SUB_PROBE_REQ, unicast_addr());
    put_element(EID_SSID, 4, -1);
    send_frame(frame_q.size() + FCS_BYTES, frame_q.size() - 1, 1'b1);
  endtask

  task automatic test_random_traffic();
    int beats0;
    beats0 = beats_sent;
    while (beats_sent - beats0 < 50) send_random_frame();
  endtask

  // back-to-back frames with no idling on either side
  task automatic test_streaming();
    int beats0;
    gaps_on = 1'b0;
    beats0  = beats_sent;
    while (beats_sent - beats0 < 30) send_random_frame();
  endtask

  // test sequence
  initial begin
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_frame_byte      <= 8'h00;
    in_frame_length    <= '0;
    in_is_management   <= 1'b0;
    in_rssi            <= 8'sh00;
    in_current_channel <= 8'h00;
    in_end_of_frame    <= 1'b0;
    clear_frame_state();
    foreach (ssid_mem[i]) ssid_mem[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_kept_frames();
    test_dropped_frames();
    test_walk_limits();
    test_truncated_frames();
    test_random_traffic();
    test_streaming();
    in_valid <= 1'b0;

    // drain
    while (expected_ssid_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!mismatch_seen) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
